// ----- hw/rtl/lmts_pkg.sv -----
// Shared types and constants for the LED matrix text scroller.
// Operation codes, display controller register codes, controller states,
// and the command/status structs between controller and datapath.
package lmts_pkg;

  // operation codes carried on s_tuser
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_FONT   = 3'd1;
  localparam logic [2:0] OP_TEXT   = 3'd2;
  localparam logic [2:0] OP_START  = 3'd3;
  localparam logic [2:0] OP_INTENS = 3'd4;
  localparam logic [2:0] OP_INIT   = 3'd5;

  // configuration register indexes
  localparam logic [3:0] CFG_PERIOD    = 4'd0;
  localparam logic [3:0] CFG_INTENSITY = 4'd1;

  // display controller registers and init values
  localparam logic [3:0] REG_DECODE    = 4'h9;
  localparam logic [3:0] REG_INTENSITY = 4'hA;
  localparam logic [3:0] REG_SCAN      = 4'hB;
  localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
  localparam logic [3:0] REG_TEST      = 4'hF;
  localparam logic [7:0] INIT_INTENS   = 8'h03;
  localparam logic [7:0] INIT_SCAN     = 8'h07;
  localparam logic [7:0] INIT_SHUTDOWN = 8'h01;

  // character mapping
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_HI     = 8'd93;
  localparam logic [7:0] CHAR_HI_OFS = 8'd33;
  localparam logic [7:0] CHAR_LO     = 8'd32;

  localparam logic [3:0] INTENS_MAX  = 4'd15;
  localparam logic [3:0] ROW_LAST    = 4'd7;
  localparam logic [3:0] INIT_LAST   = 4'd13;
  localparam logic [3:0] INIT_CTRL_N = 4'd4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TXT0,
    ST_TXT1,
    ST_TXT2,
    ST_ROWA,
    ST_ROWB,
    ST_ROWC,
    ST_BLANK,
    ST_INIT,
    ST_INTENS
  } state_t;

  typedef enum logic [1:0] {
    SRC_ROW,
    SRC_BLANK,
    SRC_INIT,
    SRC_INTENS
  } src_t;

  typedef struct packed {
    logic       accept;
    logic       clear;
    logic       txt_sel;
    logic       cap_e0;
    logic       cap_e1;
    logic       cap_d0;
    logic       font_sel;
    logic       emit;
    src_t       src;
    logic       last;
    logic [3:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       fire;
    logic       wrap;
    logic       clear_done;
    logic       out_free;
  } status_t;

endpackage

// ----- hw/rtl/led_matrix_text_scroller.sv -----
// Top level of the LED matrix text scroller: controller plus datapath.
// Depends on lmts_pkg, lmts_ctrl and lmts_datapath.
//
// Emits display controller register frames (address, data) for an 8x8 matrix.
// After reset the text buffer is cleared, during which no item is taken
// (configuration writes are). Items are taken one at a time: loads and
// non-firing ticks emit nothing; intensity emits one frame; start the blank
// frames; init the setup frames; a firing tick reads the two text characters,
// then per row does two font memory reads and the emit, plus the blank frames
// on wrap. The single read port of the font memory sets the row rate, and a
// stalled output holds these sequences.
module led_matrix_text_scroller #(
  parameter int TEXT_DEPTH     = 256,
  parameter int MAX_FONT_ENTRY = 102
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // position[7:0], font_line[10:8], data_byte[18:11], text_length[26:19],
  // loop_count[42:27], intensity_value[58:43], zero fill above
  input  logic [63:0] s_tdata,
  // operation[2:0]
  input  logic [2:0]  s_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  // reg_address[3:0], reg_data[11:4], zero fill above
  output logic [15:0] m_tdata,
  output logic        m_tlast
);

  lmts_pkg::cmd_t    cmd;
  lmts_pkg::status_t status;

  assign cfg_ready = 1'b1;

  lmts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lmts_datapath #(
    .TEXT_DEPTH     (TEXT_DEPTH),
    .MAX_FONT_ENTRY (MAX_FONT_ENTRY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- hw/rtl/lmts_ctrl.sv -----
// Controller of the LED matrix text scroller: sequences text and font reads
// and frame emission. Uses lmts_pkg; drives the datapath through cmd_t.
module lmts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  lmts_pkg::status_t status,
  output lmts_pkg::cmd_t    cmd
);

  lmts_pkg::state_t state, state_next;
  logic [3:0]       cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmts_pkg::ST_CLEAR;
      cnt   <= 4'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    s_tready   = 1'b0;
    cmd        = '0;
    cmd.src    = lmts_pkg::SRC_ROW;
    cmd.cnt    = cnt;
    unique case (state)
      lmts_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) state_next = lmts_pkg::ST_IDLE;
      end
      lmts_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        cnt_next   = 4'd0;
        if (s_tvalid) begin
          unique case (status.op)
            lmts_pkg::OP_TICK:   if (status.fire) state_next = lmts_pkg::ST_TXT0;
            lmts_pkg::OP_START:  state_next = lmts_pkg::ST_BLANK;
            lmts_pkg::OP_INTENS: state_next = lmts_pkg::ST_INTENS;
            lmts_pkg::OP_INIT:   state_next = lmts_pkg::ST_INIT;
            default:             state_next = lmts_pkg::ST_IDLE;
          endcase
        end
      end
      lmts_pkg::ST_TXT0: begin
        cmd.txt_sel = 1'b0;
        state_next  = lmts_pkg::ST_TXT1;
      end
      lmts_pkg::ST_TXT1: begin
        cmd.txt_sel = 1'b1;
        cmd.cap_e0  = 1'b1;
        state_next  = lmts_pkg::ST_TXT2;
      end
      lmts_pkg::ST_TXT2: begin
        cmd.cap_e1 = 1'b1;
        state_next = lmts_pkg::ST_ROWA;
      end
      lmts_pkg::ST_ROWA: begin
        cmd.font_sel = 1'b0;
        state_next   = lmts_pkg::ST_ROWB;
      end
      lmts_pkg::ST_ROWB: begin
        cmd.font_sel = 1'b1;
        cmd.cap_d0   = 1'b1;
        state_next   = lmts_pkg::ST_ROWC;
      end
      lmts_pkg::ST_ROWC: begin
        cmd.font_sel = 1'b1;
        cmd.emit     = 1'b1;
        cmd.src      = lmts_pkg::SRC_ROW;
        cmd.last     = (cnt == lmts_pkg::ROW_LAST) && !status.wrap;
        if (status.out_free) begin
          if (cnt == lmts_pkg::ROW_LAST) begin
            cnt_next   = 4'd0;
            state_next = status.wrap ? lmts_pkg::ST_BLANK : lmts_pkg::ST_IDLE;
          end else begin
            cnt_next   = cnt + 4'd1;
            state_next = lmts_pkg::ST_ROWA;
          end
        end
      end
      lmts_pkg::ST_BLANK: begin
        cmd.emit = 1'b1;
        cmd.src  = lmts_pkg::SRC_BLANK;
        cmd.last = (cnt == lmts_pkg::ROW_LAST);
        if (status.out_free) begin
          if (cnt == lmts_pkg::ROW_LAST) begin
            cnt_next   = 4'd0;
            state_next = lmts_pkg::ST_IDLE;
          end else begin
            cnt_next = cnt + 4'd1;
          end
        end
      end
      lmts_pkg::ST_INIT: begin
        cmd.emit = 1'b1;
        cmd.src  = lmts_pkg::SRC_INIT;
        cmd.last = (cnt == lmts_pkg::INIT_LAST);
        if (status.out_free) begin
          if (cnt == lmts_pkg::INIT_LAST) begin
            cnt_next   = 4'd0;
            state_next = lmts_pkg::ST_IDLE;
          end else begin
            cnt_next = cnt + 4'd1;
          end
        end
      end
      lmts_pkg::ST_INTENS: begin
        cmd.emit = 1'b1;
        cmd.src  = lmts_pkg::SRC_INTENS;
        cmd.last = 1'b1;
        if (status.out_free) state_next = lmts_pkg::ST_IDLE;
      end
      default: state_next = lmts_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/lmts_datapath.sv -----
// Datapath of the LED matrix text scroller: font and text memories, scroll
// state, timing, frame building and the output register. Uses lmts_pkg.
module lmts_datapath #(
  parameter int TEXT_DEPTH     = 256,
  parameter int MAX_FONT_ENTRY = 102
) (
  input  logic              clk,
  input  logic              rst,
  input  lmts_pkg::cmd_t    cmd,
  output lmts_pkg::status_t status,
  input  logic [2:0]        s_tuser,
  input  logic [63:0]       s_tdata,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,
  output logic              m_tlast
);

  localparam int TA     = $clog2(TEXT_DEPTH);
  localparam int FE     = $clog2(MAX_FONT_ENTRY + 1);
  localparam int FA     = FE + 3;
  localparam int FDEPTH = (MAX_FONT_ENTRY + 1) * 8;
  localparam logic [12:0]   DEPTH_W  = 13'(TEXT_DEPTH);
  localparam logic [7:0]    MAX_E    = 8'(MAX_FONT_ENTRY);
  localparam logic [TA-1:0] CLR_LAST = TA'(TEXT_DEPTH - 1);

  // input fields
  logic [7:0]  pos;
  logic [2:0]  fline;
  logic [7:0]  dbyte;
  logic [7:0]  tlen;
  logic [15:0] lcount;
  logic [15:0] ival;
  assign pos    = s_tdata[7:0];
  assign fline  = s_tdata[10:8];
  assign dbyte  = s_tdata[18:11];
  assign tlen   = s_tdata[26:19];
  assign lcount = s_tdata[42:27];
  assign ival   = s_tdata[58:43];

  // state
  logic [8:0]    text_len;
  logic [10:0]   scroll_column;
  logic [15:0]   loops_left;
  logic [20:0]   ticks_since;
  logic          long_pause;
  logic [15:0]   update_period;
  logic [3:0]    default_intensity;
  logic [TA-1:0] clr_addr;

  // step registers
  logic [10:0]   step_col;
  logic          step_wrap;
  logic          step_right;
  logic [FE-1:0] e0, e1;
  logic [7:0]    d0;
  logic [3:0]    inten;

  function automatic logic [FE-1:0] char_entry(input logic [7:0] code);
    logic [7:0] e;
    if (code >= lmts_pkg::CHAR_HI)      e = code - lmts_pkg::CHAR_HI_OFS;
    else if (code >= lmts_pkg::CHAR_LO) e = code - lmts_pkg::CHAR_LO;
    else                                e = 8'd0;
    if (e > MAX_E) e = 8'd0;
    return e[FE-1:0];
  endfunction

  // tick timing
  logic [20:0] ticks_inc, per21, thr;
  logic [11:0] col_inc, col_lim;
  logic        wrap_now, fire;
  assign ticks_inc = (ticks_since == '1) ? ticks_since : ticks_since + 21'd1;
  assign per21     = {5'd0, update_period};
  assign thr       = long_pause ? (per21 << 4) + (per21 << 2) + per21 : per21;  // x21
  assign fire      = (loops_left != 16'd0) && (ticks_inc >= thr);
  assign col_inc   = {1'b0, scroll_column} + 12'd1;
  assign col_lim   = {text_len, 3'b000} - 12'd1;
  assign wrap_now  = col_inc > col_lim;

  logic is_tick, is_font, is_text, is_start, is_intens;
  assign is_tick   = cmd.accept && (s_tuser == lmts_pkg::OP_TICK);
  assign is_font   = cmd.accept && (s_tuser == lmts_pkg::OP_FONT);
  assign is_text   = cmd.accept && (s_tuser == lmts_pkg::OP_TEXT);
  assign is_start  = cmd.accept && (s_tuser == lmts_pkg::OP_START);
  assign is_intens = cmd.accept && (s_tuser == lmts_pkg::OP_INTENS);

  // start length
  logic [8:0] len_req;
  assign len_req = {1'b0, tlen} + 9'd1;

  // intensity clamp
  logic [3:0] ival_clamp;
  always_comb begin
    if (ival[15])                      ival_clamp = 4'd0;
    else if (ival > 16'(lmts_pkg::INTENS_MAX)) ival_clamp = lmts_pkg::INTENS_MAX;
    else                               ival_clamp = ival[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_len          <= 9'd1;
      scroll_column     <= 11'd0;
      loops_left        <= 16'd0;
      ticks_since       <= 21'd0;
      long_pause        <= 1'b0;
      update_period     <= 16'd100;
      default_intensity <= 4'd3;
      clr_addr          <= '0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + TA'(1);
      if (cfg_we) begin
        if (cfg_index == lmts_pkg::CFG_PERIOD)    update_period     <= cfg_data;
        if (cfg_index == lmts_pkg::CFG_INTENSITY) default_intensity <= cfg_data[3:0];
      end
      if (is_tick) begin
        if (fire) begin
          ticks_since   <= 21'd0;
          long_pause    <= (scroll_column == 11'd0);
          scroll_column <= wrap_now ? 11'd0 : col_inc[10:0];
          if (wrap_now && (loops_left != 16'hFFFF)) loops_left <= loops_left - 16'd1;
        end else begin
          ticks_since <= ticks_inc;
        end
      end
      if (is_start) begin
        text_len      <= ({4'd0, len_req} > DEPTH_W) ? DEPTH_W[8:0] : len_req;
        loops_left    <= lcount;
        scroll_column <= 11'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick && fire) begin
      step_col   <= scroll_column;
      step_wrap  <= wrap_now;
      step_right <= ({1'b0, scroll_column[10:3]} + 9'd1) < text_len;
    end
    if (is_intens) inten <= ival_clamp;
  end

  // text memory
  logic [7:0]    txt_mem [TEXT_DEPTH];
  logic [7:0]    txt_q, txt_wdata;
  logic [TA-1:0] txt_waddr, txt_raddr;
  logic          txt_we;
  logic [11:0]   pos_w, rd_w;
  assign pos_w     = {4'd0, pos};
  assign rd_w      = {4'd0, step_col[10:3]} + {11'd0, cmd.txt_sel};
  assign txt_raddr = rd_w[TA-1:0];
  assign txt_we    = cmd.clear ||
                     (is_text && (pos != 8'd0) && ({5'd0, pos} < DEPTH_W));
  assign txt_waddr = cmd.clear ? clr_addr : pos_w[TA-1:0];
  assign txt_wdata = cmd.clear ? ((clr_addr == '0) ? lmts_pkg::CHAR_SPACE : 8'd0) : dbyte;

  always_ff @(posedge clk) begin
    if (txt_we) txt_mem[txt_waddr] <= txt_wdata;
    txt_q <= txt_mem[txt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_e0) e0 <= char_entry(txt_q);
    if (cmd.cap_e1) e1 <= char_entry(txt_q);
  end

  // font memory
  logic [7:0]    font_mem [FDEPTH];
  logic [7:0]    font_q;
  logic [FA-1:0] font_raddr, font_waddr;
  logic          font_we;
  assign font_we    = is_font && (pos <= MAX_E);
  assign font_waddr = {pos[FE-1:0], fline};
  assign font_raddr = {cmd.font_sel ? e1 : e0, cmd.cnt[2:0]};

  always_ff @(posedge clk) begin
    if (font_we) font_mem[font_waddr] <= dbyte;
    font_q <= font_mem[font_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_d0) d0 <= font_q;
  end

  // frame build
  logic [15:0] pair;
  logic [3:0]  fr_addr, row_addr;
  logic [7:0]  fr_data;
  assign pair     = {d0, step_right ? font_q : 8'h00} << step_col[2:0];
  assign row_addr = {1'b0, cmd.cnt[2:0]} + 4'd1;

  always_comb begin
    fr_addr = row_addr;
    fr_data = 8'h00;
    case (cmd.src)
      lmts_pkg::SRC_ROW:   fr_data = pair[15:8];
      lmts_pkg::SRC_BLANK: fr_data = 8'h00;
      lmts_pkg::SRC_INIT: begin
        case (cmd.cnt)
          4'd0: begin fr_addr = lmts_pkg::REG_DECODE;    fr_data = 8'h00; end
          4'd1: begin fr_addr = lmts_pkg::REG_INTENSITY; fr_data = lmts_pkg::INIT_INTENS; end
          4'd2: begin fr_addr = lmts_pkg::REG_SCAN;      fr_data = lmts_pkg::INIT_SCAN; end
          4'd3: begin fr_addr = lmts_pkg::REG_SHUTDOWN;  fr_data = lmts_pkg::INIT_SHUTDOWN; end
          4'd4: begin fr_addr = lmts_pkg::REG_TEST;      fr_data = 8'h00; end
          lmts_pkg::INIT_LAST: begin
            fr_addr = lmts_pkg::REG_INTENSITY;
            fr_data = {4'd0, default_intensity};
          end
          default: begin fr_addr = cmd.cnt - lmts_pkg::INIT_CTRL_N; fr_data = 8'h00; end
        endcase
      end
      lmts_pkg::SRC_INTENS: begin
        fr_addr = lmts_pkg::REG_INTENSITY;
        fr_data = {4'd0, inten};
      end
      default: fr_data = 8'h00;
    endcase
  end

  // output register
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      m_tdata <= {4'd0, fr_data, fr_addr};
      m_tlast <= cmd.last;
    end
  end

  assign status.op         = s_tuser;
  assign status.fire       = fire;
  assign status.wrap       = step_wrap;
  assign status.clear_done = (clr_addr == CLR_LAST);
  assign status.out_free   = out_free;

endmodule
